### design/integer_to_radix_ascii_unit_assert.svh
// ----------------------------------------------------------------------------
// Integer to radix ASCII assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_UNIT_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_UNIT_ASSERT_SVH

// same-cycle implication
`define ITA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("integer_to_radix_ascii_unit: assertion failed");

// next-cycle implication
`define ITA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("integer_to_radix_ascii_unit: assertion failed");

`endif

### design/ita_pkg.sv
// ----------------------------------------------------------------------------
// Integer to radix ASCII package
// Widths, character codes, control and status bundles, digit encoding.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int RADIX_BITS  = 6;
  localparam int CHAR_BITS   = 8;
  localparam int CHUNK_BITS  = 8;
  localparam int CHUNKS      = VALUE_BITS / CHUNK_BITS;
  localparam int CHUNK_IDX   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int STACK_DEPTH = VALUE_BITS;
  localparam int STACK_IDX   = $clog2(STACK_DEPTH);
  localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);
  localparam int STEP_BITS   = 4;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
  localparam logic [RADIX_BITS-1:0] DIGIT_MAX_DEC = RADIX_BITS'(9);

  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_Z     = 8'h7A;

  typedef struct packed {
    logic ready;
    logic emit_minus;
    logic clr_rem;
    logic div_iter;
    logic push;
    logic pop;
    logic emit_digit;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic negative;
    logic div_more;
    logic quot_nz;
    logic cnt_nz;
    logic out_free;
  } status_t;

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
    logic [CHAR_BITS-1:0] dw;
    dw = CHAR_BITS'(d);
    if (d > DIGIT_MAX_DEC) begin
      return dw + (CHAR_A - CHAR_BITS'(10));
    end
    return dw + CHAR_ZERO;
  endfunction

endpackage

### design/ita_div.sv
// ----------------------------------------------------------------------------
// Integer to radix ASCII divider
// Restoring division of the magnitude by the radix, one chunk of bits a step.
// ----------------------------------------------------------------------------
module ita_div
  import ita_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [VALUE_BITS-1:0] load_value,
  input  logic                  clr_rem,
  input  logic                  iter,
  input  logic [RADIX_BITS-1:0] radix,
  output logic                  more,
  output logic                  quot_nz,
  output logic [RADIX_BITS-1:0] rem
);

  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] mag_next;
  logic [RADIX_BITS-1:0] rem_next;
  logic [CHUNK_IDX-1:0]  chunk;

  always_comb begin
    logic [RADIX_BITS:0] t;
    mag_next = mag;
    rem_next = rem;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      t = {rem_next, mag_next[VALUE_BITS-1]};
      mag_next = {mag_next[VALUE_BITS-2:0], 1'b0};
      if (t >= {1'b0, radix}) begin
        t = t - {1'b0, radix};
        mag_next[0] = 1'b1;
      end
      rem_next = t[RADIX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= '0;
    end else if (clr_rem) begin
      chunk <= '0;
    end else if (iter) begin
      chunk <= (chunk == CHUNK_IDX'(CHUNKS - 1)) ? '0 : chunk + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag <= load_value;
    end else if (iter) begin
      mag <= mag_next;
    end
    if (clr_rem) begin
      rem <= '0;
    end else if (iter) begin
      rem <= rem_next;
    end
  end

  assign more    = (chunk != CHUNK_IDX'(CHUNKS - 1));
  assign quot_nz = (mag != '0);

endmodule

### design/ita_seq.sv
// ----------------------------------------------------------------------------
// Integer to radix ASCII sequencer
// Step counter over a control store with conditional jumps.
// ----------------------------------------------------------------------------
module ita_seq
  import ita_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_REQ    = 3'd2,
    COND_POSITIVE  = 3'd3,
    COND_DIV_MORE  = 3'd4,
    COND_QUOT_NZ   = 3'd5,
    COND_CNT_NZ    = 3'd6
  } cond_t;

  typedef struct packed {
    ctrl_t                act;
    cond_t                cond;
    logic [STEP_BITS-1:0] target;
  } uword_t;

  localparam logic [STEP_BITS-1:0] STEP_IDLE  = 4'd0;
  localparam logic [STEP_BITS-1:0] STEP_SIGN  = 4'd1;
  localparam logic [STEP_BITS-1:0] STEP_MINUS = 4'd2;
  localparam logic [STEP_BITS-1:0] STEP_CLEAR = 4'd3;
  localparam logic [STEP_BITS-1:0] STEP_DIV   = 4'd4;
  localparam logic [STEP_BITS-1:0] STEP_PUSH  = 4'd5;
  localparam logic [STEP_BITS-1:0] STEP_POP   = 4'd6;
  localparam logic [STEP_BITS-1:0] STEP_EMIT  = 4'd7;
  localparam logic [STEP_BITS-1:0] STEP_DONE  = 4'd8;

  localparam ctrl_t NOP = '0;

  function automatic uword_t rom(input logic [STEP_BITS-1:0] step);
    uword_t w;
    w = '{act: NOP, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.act.ready = 1'b1;
        w.cond = COND_NO_REQ;
        w.target = STEP_IDLE;
      end
      STEP_SIGN: begin
        w.cond = COND_POSITIVE;
        w.target = STEP_CLEAR;
      end
      STEP_MINUS: begin
        w.act.emit_minus = 1'b1;
        w.cond = COND_NEVER;
      end
      STEP_CLEAR: begin
        w.act.clr_rem = 1'b1;
        w.cond = COND_NEVER;
      end
      STEP_DIV: begin
        w.act.div_iter = 1'b1;
        w.cond = COND_DIV_MORE;
        w.target = STEP_DIV;
      end
      STEP_PUSH: begin
        w.act.push = 1'b1;
        w.cond = COND_QUOT_NZ;
        w.target = STEP_CLEAR;
      end
      STEP_POP: begin
        w.act.pop = 1'b1;
        w.cond = COND_NEVER;
      end
      STEP_EMIT: begin
        w.act.emit_digit = 1'b1;
        w.cond = COND_CNT_NZ;
        w.target = STEP_POP;
      end
      STEP_DONE: begin
        w.cond = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  logic [STEP_BITS-1:0] step;
  logic [STEP_BITS-1:0] step_next;
  uword_t               word;
  logic                 take;
  logic                 stall;

  assign word = rom(step);

  always_comb begin
    unique case (word.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_REQ:   take = !status.in_valid;
      COND_POSITIVE: take = !status.negative;
      COND_DIV_MORE: take = status.div_more;
      COND_QUOT_NZ:  take = status.quot_nz;
      COND_CNT_NZ:   take = status.cnt_nz;
      default:       take = 1'b0;
    endcase
  end

  assign stall = (word.act.emit_minus || word.act.emit_digit) && !status.out_free;

  always_comb begin
    priority if (stall) begin
      step_next = step;
    end else if (take) begin
      step_next = word.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl = word.act;

endmodule

### design/integer_to_radix_ascii_unit.sv
// ----------------------------------------------------------------------------
// Integer to radix ASCII unit
// Converts a signed integer to its text in a configurable radix, one
// character per output request, most significant digit first.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------
//   in       | in_valid / in_ready  | value[31:0] signed
//   out      | out_valid / out_ready| character[7:0], last
//   cfg      | cfg_we               | cfg_data[5:0] (radix)
//
// Each digit takes 6 steps of the divider (4 chunks of 8 bits plus clear
// and push) and 2 steps to pop the digit stack and emit; a negative value
// first takes a step to emit the minus sign.
// The sequencer returns to idle after the last character is registered.
// Output stalls hold the sequencer at its minus or emit step; no reset sweep.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_unit
  import ita_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [CHAR_BITS-1:0]         character,
  output logic                         last,
  input  logic                         cfg_we,
  input  logic [RADIX_BITS-1:0]        cfg_data
);

  `include "integer_to_radix_ascii_unit_assert.svh"

  ctrl_t                  ctrl;
  status_t                status;
  logic [RADIX_BITS-1:0]  radix;
  logic                   negative;
  logic [COUNT_BITS-1:0]  cnt;
  logic [COUNT_BITS-1:0]  cnt_dec;
  logic [RADIX_BITS-1:0]  stack [STACK_DEPTH];
  logic [RADIX_BITS-1:0]  rd_data;
  logic [VALUE_BITS-1:0]  value_u;
  logic [VALUE_BITS-1:0]  mag_in;
  logic                   accept;
  logic                   out_free;
  logic                   emit;
  logic                   div_more;
  logic                   quot_nz;
  logic [RADIX_BITS-1:0]  rem;
  logic                   char_ok;

  assign in_ready = ctrl.ready;
  assign accept   = in_valid && ctrl.ready;
  assign out_free = !out_valid || out_ready;
  assign emit     = (ctrl.emit_minus || ctrl.emit_digit) && out_free;
  assign cnt_dec  = cnt - 1'b1;
  assign value_u  = $unsigned(value);
  assign mag_in   = value_u[VALUE_BITS-1] ? (~value_u + 1'b1) : value_u;

  assign char_ok = (character == CHAR_MINUS) ||
                   ((character >= CHAR_ZERO) && (character <= CHAR_NINE)) ||
                   ((character >= CHAR_A) && (character <= CHAR_Z));

  assign status = '{
    in_valid: in_valid,
    negative: negative,
    div_more: div_more,
    quot_nz:  quot_nz,
    cnt_nz:   (cnt != '0),
    out_free: out_free
  };

  ita_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  ita_div u_div (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_value (mag_in),
    .clr_rem    (ctrl.clr_rem),
    .iter       (ctrl.div_iter),
    .radix      (radix),
    .more       (div_more),
    .quot_nz    (quot_nz),
    .rem        (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      priority if (cfg_data < RADIX_MIN) begin
        radix <= RADIX_MIN;
      end else if (cfg_data > RADIX_MAX) begin
        radix <= RADIX_MAX;
      end else begin
        radix <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (ctrl.push) begin
      cnt <= cnt + 1'b1;
    end else if (ctrl.pop) begin
      cnt <= cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      negative <= value_u[VALUE_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      stack[cnt[STACK_IDX-1:0]] <= rem;
    end
    if (ctrl.pop) begin
      rd_data <= stack[cnt_dec[STACK_IDX-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (ctrl.emit_minus) begin
        character <= CHAR_MINUS;
        last      <= 1'b0;
      end else begin
        character <= digit_char(rd_data);
        last      <= (cnt == '0);
      end
    end
  end

  `ITA_ASSERT_IMP(a_idle_stack_empty, in_ready, cnt == '0)
  `ITA_ASSERT_IMP(a_stack_bound, 1'b1, cnt <= COUNT_BITS'(STACK_DEPTH))
  `ITA_ASSERT_IMP(a_char_set, out_valid, char_ok)
  `ITA_ASSERT_NEXT(a_push_grows, ctrl.push, cnt == $past(cnt) + 1'b1)

endmodule

### tb/sv/integer_to_radix_ascii_unit_tb.sv
// ----------------------------------------------------------------------------
// Integer to radix ASCII unit testbench
// Sends signed integers under a range of radix settings, including the
// clamped extremes, and compares every emitted character and its last flag
// against given text or a digit-dividing predictor. Requests and
// responses both see random stall bursts, with a calm final phase.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ita_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 28;
  localparam int VECTORS      = 23;

  typedef struct {
    logic [CHAR_BITS-1:0] character;
    logic                 last;
  } text_char_t;

  typedef struct {
    bit                    set_radix;
    logic [RADIX_BITS-1:0] radix_code;
    logic [VALUE_BITS-1:0] value;
    string                 text;
  } vector_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CHAR_BITS-1:0]  character;
  logic                  last;
  logic                  cfg_we = 1'b0;
  logic [RADIX_BITS-1:0] cfg_data = '0;

  logic [RADIX_BITS-1:0] radix = RADIX_RESET;
  text_char_t            pending_chars[$];
  text_char_t            head_char;
  int                    mismatch_count = 0;
  int                    idle_cycles = 0;
  bit                    calm = 1'b0;

  vector_t directed_vectors[VECTORS] = '{
    '{1'b0, 6'd0,  32'h0000_0000, "0"},
    '{1'b0, 6'd0,  32'h7fff_ffff, "2147483647"},
    '{1'b0, 6'd0,  32'h8000_0000, "-2147483648"},
    '{1'b0, 6'd0,  32'hffff_ffff, "-1"},
    '{1'b0, 6'd0,  32'h0000_0009, "9"},
    '{1'b1, 6'd0,  32'h8000_0000, ""},
    '{1'b0, 6'd0,  32'h7fff_ffff, ""},
    '{1'b0, 6'd0,  32'hffff_ffff, "-1"},
    '{1'b1, 6'd1,  32'h0000_0005, "101"},
    '{1'b1, 6'd63, 32'h0000_0023, "z"},
    '{1'b0, 6'd0,  32'h0000_0024, "10"},
    '{1'b0, 6'd0,  32'h7fff_ffff, "zik0zj"},
    '{1'b0, 6'd0,  32'h8000_0000, "-zik0zk"},
    '{1'b1, 6'd37, 32'h0000_0000, "0"},
    '{1'b1, 6'd36, 32'hffff_ffdd, "-z"},
    '{1'b1, 6'd16, 32'h0000_00ff, "ff"},
    '{1'b0, 6'd0,  32'hdead_beef, ""},
    '{1'b1, 6'd10, 32'h0000_000a, "10"},
    '{1'b1, 6'd3,  32'h0012_d687, ""},
    '{1'b1, 6'd35, 32'h0000_0022, "y"},
    '{1'b1, 6'd2,  32'h0000_0002, "10"},
    '{1'b0, 6'd0,  32'h0000_0001, "1"},
    '{1'b1, 6'd36, 32'h4f5a_9c31, ""}
  };

  integer_to_radix_ascii_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void queue_text(input logic [VALUE_BITS-1:0] v,
                                     input logic [RADIX_BITS-1:0] base);
    logic [VALUE_BITS-1:0] magnitude;
    logic [RADIX_BITS-1:0] digits[$];
    logic [RADIX_BITS-1:0] d;
    text_char_t            c;
    magnitude = v;
    if (v[VALUE_BITS-1]) begin
      magnitude = -v;
      c.character = CHAR_MINUS;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    do begin
      digits.push_back(RADIX_BITS'(magnitude % base));
      magnitude = magnitude / base;
    end while (magnitude != 0);
    while (digits.size() != 0) begin
      d = digits.pop_back();
      c.character = (d < 10) ? CHAR_ZERO + CHAR_BITS'(d) : CHAR_A + CHAR_BITS'(d - 10);
      c.last = (digits.size() == 0);
      pending_chars.push_back(c);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic write_radix(input logic [RADIX_BITS-1:0] code);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (code < RADIX_MIN) radix = RADIX_MIN;
    else if (code > RADIX_MAX) radix = RADIX_MAX;
    else radix = code;
  endtask

  task automatic send_value(input logic [VALUE_BITS-1:0] v, input string text);
    text_char_t c;
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (!in_ready);
    if (text.len() == 0) begin
      queue_text(v, radix);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        c.character = text[i];
        c.last = (i == text.len() - 1);
        pending_chars.push_back(c);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h last %b", character, last));
      end else begin
        head_char = pending_chars.pop_front();
        if (character !== head_char.character)
          report_mismatch($sformatf("character %h, want %h", character, head_char.character));
        if (last !== head_char.last)
          report_mismatch($sformatf("last %b, want %b", last, head_char.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin
    logic [VALUE_BITS-1:0] v;
    logic [RADIX_BITS-1:0] code;
    logic [63:0]           power;
    int                    steps;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_vectors[i]) begin
      if (directed_vectors[i].set_radix) write_radix(directed_vectors[i].radix_code);
      send_value(directed_vectors[i].value, directed_vectors[i].text);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: code = 6'd0;
        1: code = 6'd63;
        2: code = RADIX_MAX;
        3: code = RADIX_MIN;
        default: code = RADIX_BITS'($urandom_range(0, 63));
      endcase
      calm = (p == PHASES - 1);
      write_radix(code);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 5))
          0: v = $urandom_range(0, 2 * radix);
          1: v = -$urandom_range(1, 2 * radix);
          2: begin
            power = 64'd1;
            steps = $urandom_range(1, 31);
            while (steps > 0 && power * radix <= 64'h8000_0000) begin
              power = power * radix;
              steps--;
            end
            v = power[VALUE_BITS-1:0] - $urandom_range(0, 1);
            if ($urandom_range(0, 1) == 1) v = -v;
          end
          3: v = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
          default: v = $urandom();
        endcase
        send_value(v, "");
      end
    end

    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
